FILE: hw/rtl/sfir_pkg.sv
package sfir_pkg;

  localparam int TAP_RADIUS_DEF = 4;
  localparam int MAX_RADIUS     = 4;
  localparam int NUM_COEF       = 4;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 16;
  localparam int PAIR_W         = SAMPLE_W + 1;
  localparam int CPROD_W        = COEF_W + SAMPLE_W;
  localparam int PROD_W         = COEF_W + PAIR_W;
  localparam int ACC_W          = PROD_W + 3;
  localparam int FRAC_W         = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [COEF_W-1:0] COEF_CENTER_RST = 16'hFFFF;
  localparam logic [ACC_W-1:0]  ROUND_HALF      = ACC_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_ONE    = 2'd1,
    CFG_TWO    = 2'd2,
    CFG_THREE  = 2'd3
  } cfg_idx_t;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]                   center;
    logic [MAX_RADIUS-2:0][PAIR_W-1:0]     pair;
    logic                                  last;
  } taps_t;

  typedef struct packed {
    logic [CPROD_W-1:0]                    center;
    logic [MAX_RADIUS-2:0][PROD_W-1:0]     prod;
    logic                                  last;
  } prods_t;

  typedef struct packed {
    logic busy;
    logic step;
  } win_stat_t;

endpackage

FILE: hw/rtl/sfir_regs.sv
module sfir_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfir_pkg::COEF_W-1:0]   cfg_data,
  output sfir_pkg::coef_bank_t          coef_o
);
  import sfir_pkg::*;

  coef_bank_t coef_r;
  coef_bank_t coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER: coef_nxt[0] = cfg_data;
        CFG_ONE:    coef_nxt[1] = cfg_data;
        CFG_TWO:    coef_nxt[2] = cfg_data;
        CFG_THREE:  coef_nxt[3] = cfg_data;
        default:    coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r    <= '0;
      coef_r[0] <= COEF_CENTER_RST;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef_o = coef_r;

endmodule

FILE: hw/rtl/sfir_window.sv
module sfir_window #(
  parameter int TAP_RADIUS = sfir_pkg::TAP_RADIUS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sfir_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_end_of_line,
  input  logic                         mac_ready,
  output logic                         taps_valid_o,
  output sfir_pkg::taps_t              taps_o,
  output sfir_pkg::win_stat_t          stat_o
);
  import sfir_pkg::*;

  localparam int WIN_LEN = 2 * TAP_RADIUS - 1;
  localparam int CENTER  = TAP_RADIUS - 1;
  localparam int CNT_W   = $clog2(TAP_RADIUS);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TAP_RADIUS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [SAMPLE_W-1:0] win_r   [WIN_LEN];
  logic [SAMPLE_W-1:0] win_nxt [WIN_LEN];
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [SAMPLE_W-1:0] hold_r;
  logic                tv_r, tv_nxt;
  taps_t               taps_r, taps_nxt;
  logic [MAX_RADIUS-2:0][PAIR_W-1:0] pair_nxt;

  logic                s1_ready;
  logic                accept;
  logic                step;
  logic                due;
  logic                final_step;
  logic [SAMPLE_W-1:0] v;

  assign s1_ready   = !tv_r || mac_ready;
  assign in_stall   = busy_r || !s1_ready;
  assign accept     = in_valid && !in_stall;
  assign step       = accept || (busy_r && s1_ready);
  assign v          = busy_r ? hold_r : in_sample;
  assign due        = (fill_r == FILL_MAX);
  assign final_step = busy_r && (cnt_r == CNT_ONE);

  always_comb begin
    win_nxt[0] = v;
    for (int i = 1; i < WIN_LEN; i++) begin
      win_nxt[i] = (fill_r == '0) ? v : win_r[i-1];
    end
  end

  for (genvar d = 1; d < MAX_RADIUS; d++) begin : g_pair
    if (d < TAP_RADIUS) begin : g_used
      assign pair_nxt[d-1] = {1'b0, win_nxt[CENTER-d]} + {1'b0, win_nxt[CENTER+d]};
    end else begin : g_unused
      assign pair_nxt[d-1] = '0;
    end
  end

  always_comb begin
    taps_nxt.center = win_nxt[CENTER];
    taps_nxt.pair   = pair_nxt;
    taps_nxt.last   = final_step;

    fill_nxt = fill_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    tv_nxt   = tv_r && !mac_ready;

    if (step) begin
      tv_nxt = due;
      if (final_step) begin
        fill_nxt = '0;
      end else if (!due) begin
        fill_nxt = fill_r + CNT_ONE;
      end
      if (busy_r) begin
        cnt_nxt = cnt_r - CNT_ONE;
        if (final_step) begin
          busy_nxt = 1'b0;
        end
      end
    end
    // end of line: replay the last sample to flush pending outputs
    if (accept && in_end_of_line) begin
      busy_nxt = 1'b1;
      cnt_nxt  = FILL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
      tv_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      tv_r   <= tv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
    if (accept) begin
      hold_r <= in_sample;
    end
    if (step && due) begin
      taps_r <= taps_nxt;
    end
  end

  assign taps_valid_o = tv_r;
  assign taps_o       = taps_r;
  assign stat_o.busy  = busy_r;
  assign stat_o.step  = step;

endmodule

FILE: hw/rtl/sfir_mac.sv
module sfir_mac #(
  parameter int TAP_RADIUS = sfir_pkg::TAP_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          taps_valid_i,
  input  sfir_pkg::taps_t               taps_i,
  input  sfir_pkg::coef_bank_t          coef_i,
  output logic                          mac_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfir_pkg::SAMPLE_W-1:0] out_filtered,
  output logic                          out_last_of_line
);
  import sfir_pkg::*;

  prods_t              prod_r, prod_nxt;
  logic                pv_r;
  logic                ov_r;
  logic [SAMPLE_W-1:0] filt_r, filt_nxt;
  logic                last_r;
  logic                out_ready;
  logic [ACC_W-1:0]    acc;

  assign out_ready = !ov_r || !out_stall;
  assign mac_ready = !pv_r || out_ready;

  assign prod_nxt.center = CPROD_W'(coef_i[0]) * CPROD_W'(taps_i.center);
  assign prod_nxt.last   = taps_i.last;

  for (genvar d = 1; d < MAX_RADIUS; d++) begin : g_prod
    if (d < TAP_RADIUS) begin : g_used
      assign prod_nxt.prod[d-1] = PROD_W'(coef_i[d]) * PROD_W'(taps_i.pair[d-1]);
    end else begin : g_unused
      assign prod_nxt.prod[d-1] = '0;
    end
  end

  always_comb begin
    acc = ACC_W'(prod_r.center) + ROUND_HALF;
    for (int d = 0; d < MAX_RADIUS - 1; d++) begin
      acc = acc + ACC_W'(prod_r.prod[d]);
    end
    if (|acc[ACC_W-1:FRAC_W+SAMPLE_W]) begin
      filt_nxt = '1;
    end else begin
      filt_nxt = acc[FRAC_W+SAMPLE_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (mac_ready) begin
        pv_r <= taps_valid_i;
      end
      if (out_ready) begin
        ov_r <= pv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_ready && taps_valid_i) begin
      prod_r <= prod_nxt;
    end
    if (out_ready && pv_r) begin
      filt_r <= filt_nxt;
      last_r <= prod_r.last;
    end
  end

  assign out_valid        = ov_r;
  assign out_filtered     = filt_r;
  assign out_last_of_line = last_r;

endmodule

FILE: hw/rtl/symmetric_fir_replicate_border.sv
// Each result passes through the tap, product and output registers, in that order.
// Throughput: one request per cycle while in_stall is low; output back-pressure
//   raises in_stall, and so does the replay of the last sample after end_of_line.
// Up to TAP_RADIUS results per request, one per cycle unless stalled, by window shift.
// Reset: synchronous, active low; clears control state, loads coefficient
//   defaults. No clearing pass.
module symmetric_fir_replicate_border #(
  parameter int TAP_RADIUS = sfir_pkg::TAP_RADIUS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfir_pkg::COEF_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sfir_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                           in_end_of_line,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sfir_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic                           out_last_of_line
);
  import sfir_pkg::*;

  coef_bank_t coef;
  taps_t      taps;
  logic       taps_valid;
  logic       mac_ready;
  win_stat_t  stat;

  sfir_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_o    (coef)
  );

  sfir_window #(.TAP_RADIUS(TAP_RADIUS)) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_end_of_line (in_end_of_line),
    .mac_ready      (mac_ready),
    .taps_valid_o   (taps_valid),
    .taps_o         (taps),
    .stat_o         (stat)
  );

  sfir_mac #(.TAP_RADIUS(TAP_RADIUS)) u_mac (
    .clk              (clk),
    .rst_n            (rst_n),
    .taps_valid_i     (taps_valid),
    .taps_i           (taps),
    .coef_i           (coef),
    .mac_ready        (mac_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_last_of_line (out_last_of_line)
  );

`ifndef SYNTH
  a_eol_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_line |=> stat.busy)
    else $error("flush not started after end of line");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> in_stall)
    else $error("request taken during flush");

  a_step_space: assert property (@(posedge clk) disable iff (!rst_n)
    taps_valid && !mac_ready |-> !stat.step || stat.busy == 1'b0 && in_stall)
    else $error("window stepped into a full tap register");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: sim/symmetric_fir_replicate_border_tb.sv
`timescale 1ns / 100ps

module symmetric_fir_replicate_border_tb;
  import sfir_pkg::*;

  localparam int RADIUS      = TAP_RADIUS_DEF;
  localparam int WIN         = 2 * RADIUS - 1;
  localparam int HOLD_CYCLES = 80;
  localparam int DOG_LIMIT   = 3000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pix;
    logic                eol;
  } line_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                last;
  } blur_out_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  cfg_idx_t            cfg_index = CFG_CENTER;
  logic [COEF_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                in_end_of_line = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_filtered;
  logic                out_last_of_line;

  line_req_t pending_req_q [$];
  blur_out_t blur_expect_q [$];

  // predictor state
  logic [SAMPLE_W-1:0] win_q [0:WIN-1];
  int                  fill_q = 0;
  logic [COEF_W-1:0]   coef_q [0:NUM_COEF-1];

  bit req_taken = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int fault_count = 0;
  int idle_cycles = 0;

  symmetric_fir_replicate_border #(
    .TAP_RADIUS(RADIUS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_last_of_line (out_last_of_line)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit shift_pixel(logic [SAMPLE_W-1:0] pix);
    bit due;
    if (fill_q == 0) begin
      for (int i = 0; i < WIN; i++) win_q[i] = pix;
    end else begin
      for (int i = WIN - 1; i > 0; i--) win_q[i] = win_q[i-1];
      win_q[0] = pix;
    end
    due = (fill_q >= RADIUS - 1);
    if (!due) fill_q++;
    return due;
  endfunction

  function automatic logic [SAMPLE_W-1:0] blur_window();
    logic [63:0] acc;
    acc = 64'(coef_q[0]) * 64'(win_q[RADIUS-1]);
    for (int d = 1; d < RADIUS; d++) begin
      acc += 64'(coef_q[d]) * (64'(win_q[RADIUS-1-d]) + 64'(win_q[RADIUS-1+d]));
    end
    acc = (acc + 64'd32768) >> FRAC_W;
    return (acc > 64'd65535) ? 16'hFFFF : acc[SAMPLE_W-1:0];
  endfunction

  task automatic predict_blur(logic [SAMPLE_W-1:0] pix, logic eol);
    blur_out_t res [$];
    blur_out_t r;
    if (shift_pixel(pix)) begin
      r.filtered = blur_window();
      r.last = 1'b0;
      res.push_back(r);
    end
    if (eol) begin
      // replay the last pixel to flush the right border
      for (int k = 0; k < RADIUS - 1; k++) begin
        if (shift_pixel(pix)) begin
          r.filtered = blur_window();
          r.last = 1'b0;
          res.push_back(r);
        end
      end
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
      fill_q = 0;
    end
    foreach (res[i]) blur_expect_q.push_back(res[i]);
  endtask

  task automatic log_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // monitor: request intake feeds the predictor, results are checked in order
  always @(posedge clk) begin
    blur_out_t exp_r;
    req_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        predict_blur(in_sample, in_end_of_line);
      end
      if (out_valid && !out_stall) begin
        if (blur_expect_q.size() == 0) begin
          log_fault($sformatf("unexpected result filtered=%h last=%b",
                              out_filtered, out_last_of_line));
        end else begin
          exp_r = blur_expect_q.pop_front();
          if (out_filtered !== exp_r.filtered)
            log_fault($sformatf("filtered exp %h got %h", exp_r.filtered, out_filtered));
          if (out_last_of_line !== exp_r.last)
            log_fault($sformatf("last_of_line exp %b got %b", exp_r.last,
                                out_last_of_line));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= DOG_LIMIT) begin
      $display("symmetric_fir_replicate_border_tb: FAIL");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    line_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = pending_req_q.pop_front();
        in_valid <= 1'b1;
        in_sample <= req.pix;
        in_end_of_line <= req.eol;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off when armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void queue_pixel(logic [SAMPLE_W-1:0] pix, logic eol);
    line_req_t req;
    req.pix = pix;
    req.eol = eol;
    pending_req_q.push_back(req);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void queue_random_lines(int n_items);
    int sent;
    int len;
    logic [SAMPLE_W-1:0] flat;
    bit is_flat;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
      is_flat = ($urandom_range(0, 5) == 0);
      flat = rand_pixel();
      for (int i = 0; i < len; i++) queue_pixel(is_flat ? flat : rand_pixel(), i == len - 1);
      sent += len;
    end
  endfunction

  task automatic drain_and_wait();
    while (pending_req_q.size() != 0 || in_valid || blur_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_coef(cfg_idx_t idx, logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    coef_q[idx] = val;
    @(posedge clk);
  endtask

  task automatic write_all_coefs(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                 logic [COEF_W-1:0] c2, logic [COEF_W-1:0] c3);
    write_coef(CFG_CENTER, c0);
    write_coef(CFG_ONE, c1);
    write_coef(CFG_TWO, c2);
    write_coef(CFG_THREE, c3);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    for (int i = 0; i < WIN; i++) win_q[i] = '0;
    coef_q[0] = COEF_CENTER_RST;
    for (int i = 1; i < NUM_COEF; i++) coef_q[i] = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset weights; short lines come only from replicated borders
    queue_pixel(16'hFFFF, 1'b1);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'hFFFF, 1'b1);
    drain_and_wait();

    // weights just under one each, summing far above one: saturation
    write_all_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 5; i++) queue_pixel(16'hFFFF, i == 4);
    queue_pixel(16'h0001, 1'b0);
    queue_pixel(16'h8000, 1'b0);
    queue_pixel(16'h7FFF, 1'b1);
    drain_and_wait();

    write_all_coefs(16'd16384, 16'd12000, 16'd8000, 16'd4000);
    queue_pixel(16'h0000, 1'b0);
    queue_pixel(16'hFFFF, 1'b0);
    queue_pixel(16'h5555, 1'b0);
    queue_pixel(16'hAAAA, 1'b0);
    queue_pixel(16'h0001, 1'b0);
    queue_pixel(16'hFFFE, 1'b0);
    queue_pixel(16'h8000, 1'b0);
    queue_pixel(16'h7FFF, 1'b1);
    for (int i = 0; i < RADIUS; i++) queue_pixel(rand_pixel(), i == RADIUS - 1);
    for (int i = 0; i < RADIUS - 1; i++) queue_pixel(rand_pixel(), i == RADIUS - 2);
    drain_and_wait();

    write_all_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
    queue_random_lines(38);
    drain_and_wait();

    send_idle_pct = 82;
    write_all_coefs(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    queue_random_lines(38);
    drain_and_wait();

    send_idle_pct = 0;
    stall_pct = 82;
    write_all_coefs(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 8191)),
                    16'($urandom_range(0, 4095)), 16'($urandom_range(0, 2047)));
    queue_random_lines(38);
    drain_and_wait();

    send_idle_pct = 28;
    stall_pct = 28;
    write_all_coefs(rand_coef(), 16'h0000, rand_coef(), rand_coef());
    queue_random_lines(38);
    drain_and_wait();

    // receiver holds off while requests keep coming
    send_idle_pct = 0;
    stall_pct = 0;
    write_all_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
    hold_arm = 1'b1;
    queue_random_lines(38);
    drain_and_wait();

    if (blur_expect_q.size() != 0)
      log_fault($sformatf("%0d results never arrived", blur_expect_q.size()));
    if (fault_count == 0) begin
      $display("symmetric_fir_replicate_border_tb: PASS");
    end else begin
      $display("symmetric_fir_replicate_border_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sfir_pkg.sv
hw/rtl/sfir_regs.sv
hw/rtl/sfir_window.sv
hw/rtl/sfir_mac.sv
hw/rtl/symmetric_fir_replicate_border.sv
sim/symmetric_fir_replicate_border_tb.sv
